// File: rtl/rfsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsl_pkg
// Shared types and constants for the range filter table: item layouts,
// opcodes, status codes, sequencer states and the cell control group.
// ----------------------------------------------------------------------------
package rfsl_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int ID_WIDTH    = 29;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_COMMIT = 2'd2,
    OP_LOOKUP = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RANGE = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESULT
  } fsm_state_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [ID_WIDTH-1:0] lower_bound;
    logic [ID_WIDTH-1:0] upper_bound;
    logic [ID_WIDTH-1:0] key;
  } cmd_t;

  typedef struct packed {
    status_t    status;
    logic       hit;
    logic [4:0] match_index;
  } result_t;

  // control group broadcast to every cell of the row
  typedef struct packed {
    logic                insert;
    logic [ID_WIDTH-1:0] lo;
    logic [ID_WIDTH-1:0] hi;
    logic [ID_WIDTH-1:0] key;
    logic [CNT_W-1:0]    count;
  } cell_ctrl_t;

endpackage

// File: rtl/rfsl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsl_cell
// One slot of the sorted range row. Holds one (lower, upper) range, takes
// part in sorted insertion by shifting toward its right neighbor, and
// registers its own order-check and lookup-match flags each cycle.
// ----------------------------------------------------------------------------
module rfsl_cell (
  input  logic                              clk,
  input  rfsl_pkg::cell_ctrl_t              ctrl,
  input  logic [rfsl_pkg::CNT_W-1:0]        slot,
  input  logic                              left_gt,
  input  logic [rfsl_pkg::ID_WIDTH-1:0]     left_lo,
  input  logic [rfsl_pkg::ID_WIDTH-1:0]     left_hi,
  output logic                              gt,
  output logic [rfsl_pkg::ID_WIDTH-1:0]     lo,
  output logic [rfsl_pkg::ID_WIDTH-1:0]     hi,
  output logic                              err,
  output logic                              match
);
  import rfsl_pkg::*;

  logic occ;
  logic first;

  assign occ   = slot < ctrl.count;
  assign first = slot == '0;
  // empty slots count as above any new lower bound; ties stay ahead
  assign gt    = !occ || (lo > ctrl.lo);

  always_ff @(posedge clk) begin
    if (ctrl.insert && gt) begin
      if (left_gt) begin
        lo <= left_lo;
        hi <= left_hi;
      end else begin
        lo <= ctrl.lo;
        hi <= ctrl.hi;
      end
    end
    err   <= occ && ((lo > hi) || (!first && (lo <= left_hi)));
    match <= occ && (ctrl.key >= lo) && (ctrl.key <= hi);
  end

endmodule

// File: rtl/rfsl_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsl_chain
// The row of range cells with neighbor links, plus the reduction of the
// per-cell flags into an order error, a hit and the hit position.
// ----------------------------------------------------------------------------
module rfsl_chain (
  input  logic                          clk,
  input  rfsl_pkg::cell_ctrl_t          ctrl,
  output logic                          err_any,
  output logic                          match_any,
  output logic [rfsl_pkg::IDX_W-1:0]    match_idx
);
  import rfsl_pkg::*;

  logic [TABLE_DEPTH:0]    gt_link;
  logic [ID_WIDTH-1:0]     lo_link [TABLE_DEPTH+1];
  logic [ID_WIDTH-1:0]     hi_link [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0]  err_vec;
  logic [TABLE_DEPTH-1:0]  match_vec;

  assign gt_link[0] = 1'b0;
  assign lo_link[0] = '0;
  assign hi_link[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rfsl_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .slot    (CNT_W'(i)),
      .left_gt (gt_link[i]),
      .left_lo (lo_link[i]),
      .left_hi (hi_link[i]),
      .gt      (gt_link[i+1]),
      .lo      (lo_link[i+1]),
      .hi      (hi_link[i+1]),
      .err     (err_vec[i]),
      .match   (match_vec[i])
    );
  end

  assign err_any   = |err_vec;
  assign match_any = |match_vec;

  // committed ranges are disjoint, so at most one cell matches
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (match_vec[i]) begin
        match_idx = match_idx | IDX_W'(i);
      end
    end
  end

endmodule

// File: rtl/range_filter_sort_and_lookup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_filter_sort_and_lookup_core
// Identifier range acceptance table: clear, append, commit, lookup.
// ----------------------------------------------------------------------------
// Each item is accepted on start while busy is low, works in S_EXEC in the
// row of range cells (sorted insertion, or each cell checking its own range
// and comparing the key), is reduced from the registered cell flags in
// S_RESULT, and its result then shows on result with done high for exactly
// one cycle. busy is low in that cycle, so the next item can be accepted in
// it; a new item is not taken until the last one is through. Ranges are kept
// sorted by lower bound as they are appended, so a commit only checks
// neighbors. The receiver cannot stall: a result not taken while done is high
// is overwritten by the next item's result.
module range_filter_sort_and_lookup_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rfsl_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done,
  output rfsl_pkg::result_t result
);
  import rfsl_pkg::*;

  fsm_state_t       state;
  fsm_state_t       state_next;
  cmd_t             req;
  logic [CNT_W-1:0] count;
  logic             committed;
  logic             dropped;
  logic             full;
  logic             do_insert;
  logic             err_any;
  logic             match_any;
  logic [IDX_W-1:0] match_idx;
  logic [IDX_W+4:0] idx_ext;
  result_t          result_next;
  cell_ctrl_t       ctrl;

  assign full      = count == CNT_W'(TABLE_DEPTH);
  assign do_insert = (state == S_EXEC) && (req.opcode == OP_APPEND) && !full;
  assign busy      = state != S_IDLE;
  assign idx_ext   = {5'b0, match_idx};

  assign ctrl.insert = do_insert;
  assign ctrl.lo     = req.lower_bound;
  assign ctrl.hi     = req.upper_bound;
  assign ctrl.key    = req.key;
  assign ctrl.count  = count;

  rfsl_chain u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .err_any   (err_any),
    .match_any (match_any),
    .match_idx (match_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    result_next = '{status: ST_OK, hit: 1'b0, match_index: 5'd0};
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        state_next = S_IDLE;
        case (req.opcode)
          OP_APPEND: begin
            if (dropped) begin
              result_next.status = ST_FULL;
            end
          end
          OP_COMMIT: begin
            if (err_any) begin
              result_next.status = ST_BAD_RANGE;
            end
          end
          OP_LOOKUP: begin
            if (committed && match_any) begin
              result_next.hit         = 1'b1;
              result_next.match_index = idx_ext[4:0];
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      committed <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= state == S_RESULT;
      if (state == S_EXEC) begin
        case (req.opcode)
          OP_CLEAR: begin
            count     <= '0;
            committed <= 1'b0;
          end
          OP_APPEND: begin
            if (!full) begin
              count     <= count + 1'b1;
              committed <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      if ((state == S_RESULT) && (req.opcode == OP_COMMIT)) begin
        if (err_any) begin
          count     <= '0;
          committed <= 1'b0;
        end else begin
          committed <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      req <= cmd;
    end
    if (state == S_EXEC) begin
      dropped <= full;
    end
    if (state == S_RESULT) begin
      result <= result_next;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while an item is still in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.hit) |-> (result.status == ST_OK))
    else $error("hit reported with a non-ok status");

  a_fail_empties: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_BAD_RANGE)) |-> ((count == '0) && !committed))
    else $error("failed commit left ranges in the table");

endmodule
